// ----- sv/tcc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and value helpers for the thermometer click counter.
// Depends on nothing; every other file of the block imports it.
package tcc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_AUTO_ROLLOVER    = 2'd0,
    CFG_ROLLOVER_FLASHES = 2'd1,
    CFG_FLASH_BIT        = 2'd2,
    CFG_DIM_MASK         = 2'd3
  } cfg_idx_e;

  // Power-on setup sequence, one-hot.
  typedef enum logic [2:0] {
    SETUP_WAIT_PRESS   = 3'b001,
    SETUP_WAIT_RELEASE = 3'b010,
    SETUP_RUN          = 3'b100
  } setup_e;

  localparam int unsigned LedCountDefault = 8;
  localparam logic [7:0] StartValue  = 8'h0f;
  localparam logic       AutoRollRst = 1'b1;
  localparam logic [7:0] RollFlashRst = 8'd3;
  localparam logic [2:0] FlashBitRst = 3'd6;
  localparam logic [7:0] DimMaskRst  = 8'h07;
  localparam int unsigned CfgDataW   = 8;

  typedef struct packed {
    logic       auto_rollover;
    logic [7:0] rollover_flashes;
    logic [2:0] flash_bit;
    logic [7:0] dim_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] flash_count;
    logic       click_pressed;
    logic       add_pressed;
    logic       mode_held;
  } item_t;

  // Add one lit LED at the top of a thermometer value, saturating at the mask.
  function automatic logic [7:0] grow(input logic [7:0] v, input logic [7:0] m);
    if ((v & m) != m) begin
      return ((v << 1) | 8'd1) & m;
    end
    return m;
  endfunction

  // Remove the top LED, or wrap around when the value sits at its minimum.
  function automatic logic [7:0] shrink(input logic [7:0] v, input logic [7:0] lowest,
                                        input logic [7:0] wrapto);
    if (v != lowest) begin
      return v >> 1;
    end
    return wrapto;
  endfunction

endpackage

// ----- sv/tcc_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file of the thermometer click counter.
// Depends on tcc_pkg for the register index codes and the cfg_t bundle.
module tcc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [1:0]                 index_i,
  input  logic [tcc_pkg::CfgDataW-1:0] data_i,
  output tcc_pkg::cfg_t              cfg_o
);
  import tcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_AUTO_ROLLOVER:    cfg_d.auto_rollover    = data_i[0];
        CFG_ROLLOVER_FLASHES: cfg_d.rollover_flashes = data_i;
        CFG_FLASH_BIT:        cfg_d.flash_bit        = data_i[2:0];
        CFG_DIM_MASK:         cfg_d.dim_mask         = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{auto_rollover: AutoRollRst, rollover_flashes: RollFlashRst,
                 flash_bit: FlashBitRst, dim_mask: DimMaskRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/tcc_core.sv -----
`timescale 1ns / 1ps
// Tick logic of the thermometer click counter: setup sequence, value updates,
// rollover timeout and the LED byte. Depends on tcc_pkg.
module tcc_core #(
  parameter int unsigned LED_COUNT = tcc_pkg::LedCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  tcc_pkg::item_t item_i,
  input  tcc_pkg::cfg_t  cfg_i,
  output logic [7:0]    leds_o
);
  import tcc_pkg::*;

  localparam logic [7:0] LedMask = (LED_COUNT >= 8) ? 8'hff : 8'((1 << LED_COUNT) - 1);

  setup_e     setup_q, setup_d;
  logic       perm_q, perm_d;
  logic [7:0] full_q, full_d;
  logic [7:0] turn_q, turn_d;
  logic [7:0] left_q, left_d;
  logic [7:0] seen_q, seen_d;
  logic       phase;

  assign phase = item_i.flash_count[cfg_i.flash_bit];

  always_comb begin
    setup_d = setup_q;
    perm_d  = perm_q;
    full_d  = full_q;
    turn_d  = turn_q;
    left_d  = left_q;
    seen_d  = seen_q;

    unique case (setup_q)
      SETUP_WAIT_PRESS: begin
        if (item_i.mode_held) begin
          setup_d = SETUP_WAIT_RELEASE;
        end
      end
      SETUP_WAIT_RELEASE: begin
        if (!item_i.mode_held) begin
          setup_d = SETUP_RUN;
          turn_d  = full_q;
        end
      end
      SETUP_RUN: perm_d = item_i.mode_held;
      default: ;
    endcase

    if (perm_d) begin
      if (item_i.add_pressed) begin
        full_d = grow(full_d, LedMask);
        left_d = '0;
      end
      if (item_i.click_pressed) begin
        full_d = shrink(full_d, 8'd1, 8'd1);
        left_d = '0;
      end
    end else begin
      if (item_i.add_pressed) begin
        turn_d = grow(turn_d, LedMask);
        left_d = '0;
      end
      if (item_i.click_pressed) begin
        turn_d = shrink(turn_d, 8'd0, full_d);
        left_d = '0;
      end
    end

    if (!phase) begin
      seen_d = '0;
    end
    if (left_d != '0) begin
      if (phase && (left_d != seen_d)) begin
        left_d = left_d - 8'd1;
        seen_d = left_d;
      end
      if (left_d == '0) begin
        turn_d = full_d;
      end
    end else if ((turn_d == '0) && cfg_i.auto_rollover) begin
      left_d = cfg_i.rollover_flashes;
    end

    if (perm_d) begin
      leds_o = phase ? full_d : 8'd0;
    end else begin
      leds_o = turn_d;
      if ((item_i.flash_count & cfg_i.dim_mask) == '0) begin
        leds_o = leds_o | full_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= SETUP_WAIT_PRESS;
      perm_q  <= 1'b1;
      full_q  <= StartValue & LedMask;
      turn_q  <= StartValue & LedMask;
      left_q  <= '0;
      seen_q  <= '0;
    end else if (step_i) begin
      setup_q <= setup_d;
      perm_q  <= perm_d;
      full_q  <= full_d;
      turn_q  <= turn_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ----- sv/thermometer_click_counter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the thermometer click counter: input and result registers around
// the tick logic and the configuration registers. Depends on tcc_pkg, tcc_cfg, tcc_core.
//
//  Channel        Direction  Word contents (lowest bit first)
//  s_axis         in         mode_held, add_pressed, click_pressed, flash_count[7:0]
//  m_axis         out        leds[7:0]
//  cfg            in         register index, 8-bit write data
//
// Every tick word yields exactly one LED word. A word is accepted into the input
// register, then the tick logic updates the state and loads the result register.
// Both sides run at one word per cycle; a stall on m_axis holds the result,
// then the input register, and only then drops s_axis_tready.
// Reset (rst_ni low, asynchronous) empties both registers and restores the
// power-on state and the register defaults; no clearing pass is needed.
module thermometer_click_counter_unit #(
  parameter int unsigned LED_COUNT = tcc_pkg::LedCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] mode_held, [1] add_pressed,
                                     // [2] click_pressed, [10:3] flash_count, rest zero
  // LED words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] leds
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import tcc_pkg::*;

  cfg_t       cfg;
  item_t      item_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic [7:0] leds_q;
  logic [7:0] leds_d;
  logic       s_fire;
  logic       advance;

  // Registers are always writable; software must write only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  tcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // The held word moves on whenever the result register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_t'(s_axis_tdata[10:0]);
    end
  end

  tcc_core #(
    .LED_COUNT (LED_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .leds_o (leds_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      leds_q <= leds_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = leds_q;

  // An accepted tick word is held in the input register on the next cycle.
  a_accept_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> in_valid_q)
    else $error("accepted tick word not held");

  // A stalled result is never dropped.
  a_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("stalled LED word dropped");

  // With both registers full and the output stalled, the held word stays put.
  a_input_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |=> in_valid_q && !$past(s_axis_tready))
    else $error("held tick word lost under stall");

endmodule
